// ===== sv/c_string_escape_encoder_macros.svh =====
// Assertion macros used by the escape encoder top level.
`ifndef C_STRING_ESCAPE_ENCODER_MACROS_SVH
`define C_STRING_ESCAPE_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escape encoder check failed");

// Next-cycle implication, disabled during reset.
`define CSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("escape encoder check failed");

`endif

// ===== sv/cse_pkg.sv =====
// Types, codes and the byte classifier of the C string escape encoder.
package cse_pkg;

    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [7:0] CH_QUOTE     = 8'd34;
    localparam logic [7:0] CH_BACKSLASH = 8'd92;
    localparam logic [7:0] CH_ZERO      = 8'd48;
    localparam logic [7:0] PRINT_LOW    = 8'd32;
    localparam logic [7:0] PRINT_HIGH   = 8'd126;
    localparam logic [7:0] NAMED_FIRST  = 8'd7;
    localparam logic [7:0] NAMED_LAST   = 8'd13;

    localparam int QUEUE_DEPTH = 2;

    // One classified item: up to four characters and the index of the last one.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
    } run_t;

    // Letter of a named escape, indexed by byte minus 7.
    function automatic logic [7:0] named_letter(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'd97;   // a
            3'd1:    ch = 8'd98;   // b
            3'd2:    ch = 8'd116;  // t
            3'd3:    ch = 8'd110;  // n
            3'd4:    ch = 8'd118;  // v
            3'd5:    ch = 8'd102;  // f
            default: ch = 8'd114;  // r
        endcase
        return ch;
    endfunction

    function automatic run_t encode_byte(input logic [7:0] b);
        run_t r;
        logic [7:0] off;
        off        = b - NAMED_FIRST;
        r.chars    = '0;
        r.last_idx = 2'd0;
        if (b == CH_QUOTE || b == CH_BACKSLASH) begin
            r.chars[0] = CH_BACKSLASH;
            r.chars[1] = b;
            r.last_idx = 2'd1;
        end
        else if (b >= NAMED_FIRST && b <= NAMED_LAST) begin
            r.chars[0] = CH_BACKSLASH;
            r.chars[1] = named_letter(off[2:0]);
            r.last_idx = 2'd1;
        end
        else if (b >= PRINT_LOW && b <= PRINT_HIGH) begin
            r.chars[0] = b;
        end
        else begin
            r.chars[0] = CH_BACKSLASH;
            r.chars[1] = CH_ZERO | {6'd0, b[7:6]};
            r.chars[2] = CH_ZERO | {5'd0, b[5:3]};
            r.chars[3] = CH_ZERO | {5'd0, b[2:0]};
            r.last_idx = 2'd3;
        end
        return r;
    endfunction

endpackage

// ===== sv/cse_in_if.sv =====
// Input channel: operation code and raw byte.
interface cse_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// ===== sv/cse_out_if.sv =====
// Output channel: one escaped character per beat.
interface cse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// ===== sv/c_string_escape_encoder.sv =====
// An accepted item goes through a queue entry and then the serializer run register.
// The serializer sends one output character per cycle while the output is ready; an item
// gives one for a quote or plain byte, two for a prefixed or named escape, four for octal.
// A two-entry queue lets the input take items while the serializer works or is stalled.
// Reset (rst_n low, asynchronous) empties the queue and the serializer; nothing else is kept.
`include "c_string_escape_encoder_macros.svh"
module c_string_escape_encoder (
    input  logic      clk,
    input  logic      rst_n,
    cse_in_if.sink    din,
    cse_out_if.source dout
);
    import cse_pkg::*;

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    run_t push_run, pop_run;
    logic in_beat, out_beat, last_beat;

    cse_front u_front (
        .din        (din),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_run   (push_run)
    );

    cse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_run   (push_run),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_run    (pop_run)
    );

    cse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_run   (pop_run),
        .dout      (dout)
    );

    assign in_beat   = din.valid && din.ready && (din.op != OP_UNUSED);
    assign out_beat  = dout.valid && dout.ready;
    assign last_beat = out_beat && dout.last_of_run;

    // an item that yields characters is held somewhere right after it is taken
    `CSE_ASSERT_NEXT(a_item_held, clk, rst_n, in_beat, pop_valid || dout.valid)
    // a run keeps the output busy until its final beat
    `CSE_ASSERT_NEXT(a_run_continues, clk, rst_n, out_beat && !dout.last_of_run, dout.valid)
    // output goes idle after a final beat with nothing queued
    `CSE_ASSERT_NEXT(a_idle_after_last, clk, rst_n, last_beat && !pop_valid, !dout.valid)
    // the serializer never sits idle while the queue holds a run
    `CSE_ASSERT_NOW(a_no_idle_with_work, clk, rst_n, pop_valid && !dout.valid, pop_ready)
endmodule

// ===== sv/cse_front.sv =====
// Front end: accept input beats, classify them and push runs to the queue.
module cse_front (
    cse_in_if.sink      din,
    output logic        push_valid,
    input  logic        push_ready,
    output cse_pkg::run_t push_run
);
    import cse_pkg::*;

    run_t quote_run;

    always_comb
    begin
        quote_run          = '0;
        quote_run.chars[0] = CH_QUOTE;
    end

    assign din.ready = push_ready;

    always_comb
    begin
        push_valid = 1'b0;
        push_run   = quote_run;
        unique case (din.op) inside
            OP_BEGIN, OP_END:
            begin
                push_valid = din.valid;
            end
            OP_DATA:
            begin
                push_valid = din.valid;
                push_run   = encode_byte(din.data_byte);
            end
            default:
            begin
                // drop the unused op code
                push_valid = 1'b0;
            end
        endcase
    end
endmodule

// ===== sv/cse_queue.sv =====
// Short queue of classified runs between front and back.
module cse_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  cse_pkg::run_t push_run,
    output logic          pop_valid,
    input  logic          pop_ready,
    output cse_pkg::run_t pop_run
);
    import cse_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    run_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_run    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end
endmodule

// ===== sv/cse_back.sv =====
// Back end: serialize each run into output beats, one character per cycle while the output is ready.
module cse_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  cse_pkg::run_t pop_run,
    cse_out_if.source     dout
);
    import cse_pkg::*;

    run_t       run_reg, run_next;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       at_last, beat;

    assign at_last          = (idx_reg == run_reg.last_idx);
    assign beat             = dout.valid && dout.ready;
    assign dout.valid       = busy_reg;
    assign dout.out_char    = run_reg.chars[idx_reg];
    assign dout.last_of_run = at_last;

    // take a new run when empty or when the final beat of the current one leaves
    assign pop_ready = !busy_reg || (beat && at_last);

    always_comb
    begin
        run_next  = run_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (pop_ready)
        begin
            busy_next = pop_valid;
            run_next  = pop_run;
            idx_next  = 2'd0;
        end
        else if (beat)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
    end
endmodule
